// File: hdl/largest_connected_component_unit_defines.svh
// Assertion macros for the largest connected component unit.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LARGEST_CONNECTED_COMPONENT_UNIT_DEFINES_SVH
`define LARGEST_CONNECTED_COMPONENT_UNIT_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define LCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define LCC_NEVER(lbl, cond, msg) \
  `LCC_ASSERT(lbl, !(cond), msg)

`endif

// File: hdl/lcc_pkg.sv
// Shared types and constants for the largest connected component unit.
// No dependencies.
package lcc_pkg;

  // Width of vertex numbers, counts and sizes on the ports
  localparam int SIZE_W = 7;

  // Stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Item kinds carried in tuser
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WX,
    ST_EDGE_WY,
    ST_SCAN,
    ST_ROW,
    ST_PUSH,
    ST_POP,
    ST_DONE
  } state_e;

endpackage

// File: hdl/lcc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lcc_first_set.sv
// Priority encoder: index of the lowest set bit of a vector.
// No dependencies.
module lcc_first_set #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         vec_i,
  output logic                     found_o,
  output logic [$clog2(WIDTH)-1:0] idx_o
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    idx_o = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = ($clog2(WIDTH))'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

// File: hdl/largest_connected_component_unit.sv
// Top level of the largest connected component unit: edge loader and DFS sequencer.
// Depends on lcc_pkg, lcc_ram, lcc_first_set and largest_connected_component_unit_defines.svh.
//
//  channel  | dir | payload (low bit first)                         | transfer when
//  ---------+-----+-------------------------------------------------+---------------------
//  s_axis   | in  | tuser: op; tdata: first_vertex, second_vertex   | tvalid & tready
//  m_axis   | out | tdata: largest_size                             | tvalid & tready
//  cfg      | in  | cfg_wdata_i: vertex_count                       | cfg_we_i
//
// An edge is a read-modify-write of both rows (one row for a self loop, none if ignored).
// A finish runs a depth-first search per component, paced by the one read port
// of the adjacency memory and of the stack memory.
// Rows carry valid bits cleared by reset and after each finish, so no clearing pass is run.
// Input is taken in idle only, and only when the result register is free or draining.
`include "largest_connected_component_unit_defines.svh"

module largest_connected_component_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: vertex_count
  input  logic                           cfg_we_i,
  input  logic [lcc_pkg::SIZE_W-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [6:0] first_vertex, [13:7] second_vertex
  input  logic                           s_axis_tuser,  // [0] op
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lcc_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [6:0] largest_size
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int SPW = $clog2(MAX_VERTICES + 1);
  localparam int SW  = lcc_pkg::SIZE_W;
  localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

  // State
  lcc_pkg::state_e state_q, state_d;
  logic [SW-1:0]           vc_q;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] rvalid_q, rvalid_d;
  logic [MAX_VERTICES-1:0] fresh_q, fresh_d;
  logic [SPW-1:0]          sp_q, sp_d;
  logic [SW-1:0]           size_q, size_d;
  logic [SW-1:0]           best_q, best_d;
  logic [VW-1:0]           ex_q, ey_q;
  logic                    rd_valid_q;
  logic                    m_tvalid_q, m_tvalid_d;
  logic [SW-1:0]           m_data_q, m_data_d;

  // Memory ports
  logic                    adj_we, adj_re;
  logic [VW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    stk_we, stk_re;
  logic [VW-1:0]           stk_waddr, stk_raddr;
  logic [VW-1:0]           stk_wdata, stk_rdata;

  // Decode
  logic                    in_xfer;
  logic [SW-1:0]           vtx_a, vtx_b, a_m1, b_m1, n_eff;
  logic                    edge_ok;
  logic [MAX_VERTICES-1:0] mask, row, cand;
  logic                    scan_found, push_found;
  logic [VW-1:0]           scan_idx, push_idx;

  assign vtx_a   = s_axis_tdata[SW-1:0];
  assign vtx_b   = s_axis_tdata[2*SW-1:SW];
  assign a_m1    = vtx_a - SW'(1);
  assign b_m1    = vtx_b - SW'(1);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign n_eff   = (vc_q > SW'(MAX_VERTICES)) ? SW'(MAX_VERTICES) : vc_q;
  assign edge_ok = (vtx_a != '0) && (vtx_b != '0) && (vtx_a <= n_eff) && (vtx_b <= n_eff);

  // Vertices below the effective count
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (SW'(i) < n_eff);
    end
  end

  // Rows never written since the last clear read as zero
  assign row  = rd_valid_q ? adj_rdata : '0;
  assign cand = mask & ~visited_q;

  lcc_first_set #(.WIDTH(MAX_VERTICES)) u_scan_enc (
    .vec_i   (cand),
    .found_o (scan_found),
    .idx_o   (scan_idx)
  );

  lcc_first_set #(.WIDTH(MAX_VERTICES)) u_push_enc (
    .vec_i   (fresh_q),
    .found_o (push_found),
    .idx_o   (push_idx)
  );

  lcc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  lcc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == lcc_pkg::OP_FINISH) begin
            state_d = lcc_pkg::ST_SCAN;
          end else if (edge_ok) begin
            state_d = lcc_pkg::ST_EDGE_WX;
          end
        end
      end
      lcc_pkg::ST_EDGE_WX: state_d = (ex_q == ey_q) ? lcc_pkg::ST_IDLE : lcc_pkg::ST_EDGE_WY;
      lcc_pkg::ST_EDGE_WY: state_d = lcc_pkg::ST_IDLE;
      lcc_pkg::ST_SCAN:    state_d = scan_found ? lcc_pkg::ST_ROW : lcc_pkg::ST_DONE;
      lcc_pkg::ST_ROW:     state_d = lcc_pkg::ST_PUSH;
      lcc_pkg::ST_PUSH: begin
        if (push_found) begin
          state_d = lcc_pkg::ST_PUSH;
        end else if (sp_q != '0) begin
          state_d = lcc_pkg::ST_POP;
        end else begin
          state_d = lcc_pkg::ST_SCAN;
        end
      end
      lcc_pkg::ST_POP:  state_d = lcc_pkg::ST_ROW;
      lcc_pkg::ST_DONE: state_d = lcc_pkg::ST_IDLE;
      default:          state_d = lcc_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = ex_q;
    adj_wdata = row | (ONE << ey_q);
    adj_re    = 1'b0;
    adj_raddr = ey_q;
    stk_we    = 1'b0;
    stk_waddr = sp_q[VW-1:0];
    stk_wdata = push_idx;
    stk_re    = 1'b0;
    stk_raddr = stk_waddr - VW'(1);
    s_axis_tready = 1'b0;
    case (state_q)
      lcc_pkg::ST_IDLE: begin
        s_axis_tready = !m_tvalid_q || m_axis_tready;
        adj_re        = in_xfer && (s_axis_tuser == lcc_pkg::OP_EDGE) && edge_ok;
        adj_raddr     = a_m1[VW-1:0];
      end
      lcc_pkg::ST_EDGE_WX: begin
        adj_we = 1'b1;
        adj_re = 1'b1;
      end
      lcc_pkg::ST_EDGE_WY: begin
        adj_we    = 1'b1;
        adj_waddr = ey_q;
        adj_wdata = row | (ONE << ex_q);
      end
      lcc_pkg::ST_SCAN: begin
        adj_re    = scan_found;
        adj_raddr = scan_idx;
      end
      lcc_pkg::ST_PUSH: begin
        stk_we = push_found;
        stk_re = !push_found && (sp_q != '0);
      end
      lcc_pkg::ST_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    visited_d  = visited_q;
    rvalid_d   = rvalid_q;
    fresh_d    = fresh_q;
    sp_d       = sp_q;
    size_d     = size_q;
    best_d     = best_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    if (adj_we) begin
      rvalid_d = rvalid_d | (ONE << adj_waddr);
    end
    case (state_q)
      lcc_pkg::ST_SCAN: begin
        if (scan_found) begin
          visited_d = visited_q | (ONE << scan_idx);
          size_d    = SW'(1);
        end
      end
      lcc_pkg::ST_ROW: begin
        fresh_d   = row & mask & ~visited_q;
        visited_d = visited_q | (row & mask);
      end
      lcc_pkg::ST_PUSH: begin
        if (push_found) begin
          fresh_d = fresh_q & ~(ONE << push_idx);
          sp_d    = sp_q + SPW'(1);
        end else if (sp_q != '0) begin
          sp_d = sp_q - SPW'(1);
        end else if (size_q > best_q) begin
          best_d = size_q;
        end
      end
      lcc_pkg::ST_POP: size_d = size_q + SW'(1);
      lcc_pkg::ST_DONE: begin
        m_tvalid_d = 1'b1;
        m_data_d   = best_q;
        visited_d  = '0;
        rvalid_d   = '0;
        sp_d       = '0;
        best_d     = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcc_pkg::ST_IDLE;
      vc_q       <= '0;
      visited_q  <= '0;
      rvalid_q   <= '0;
      sp_q       <= '0;
      size_q     <= '0;
      best_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      visited_q  <= visited_d;
      rvalid_q   <= rvalid_d;
      sp_q       <= sp_d;
      size_q     <= size_d;
      best_q     <= best_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fresh_q  <= fresh_d;
    m_data_q <= m_data_d;
    if (adj_re) begin
      rd_valid_q <= rvalid_q[adj_raddr];
    end
    if (state_q == lcc_pkg::ST_IDLE) begin
      ex_q <= a_m1[VW-1:0];
      ey_q <= b_m1[VW-1:0];
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {{(lcc_pkg::OUT_DATA_W - SW){1'b0}}, m_data_q};

  // Checks
  `LCC_NEVER(a_sp_bound, sp_q > SPW'(MAX_VERTICES), "stack pointer beyond vertex limit")
  `LCC_NEVER(a_size_bound, size_q > SW'(MAX_VERTICES) && state_q != lcc_pkg::ST_IDLE, "component size beyond vertex limit")
  `LCC_ASSERT(a_push_visited, (state_q == lcc_pkg::ST_PUSH && push_found) |-> visited_q[push_idx], "pushed vertex not marked visited")
  `LCC_ASSERT(a_clear_after_done, (state_q == lcc_pkg::ST_DONE) |=> (visited_q == '0 && rvalid_q == '0 && sp_q == '0), "graph not cleared after finish")
  `LCC_ASSERT(a_result_from_done, $rose(m_tvalid_q) |-> $past(state_q == lcc_pkg::ST_DONE), "result raised outside finish")

endmodule
